// ----- src/sps_pkg.sv -----
// shared types, constants and syntax tables of the sps header parser
`timescale 1ns / 1ps
package sps_pkg;

    localparam int GOLOMB_MAX_BITS  = 32;
    localparam int DIM_BITS         = 16;
    localparam int MAX_CYCLE_FRAMES = 255;
    localparam int DIM_MAX_MBS      = (1 << (DIM_BITS - 4)) - 2;
    localparam int DIM_LIMIT        = (1 << DIM_BITS) - 1;

    typedef enum logic [5:0] {
        SX_HDR = 6'd0, SX_PROFILE = 6'd1, SX_CONSTR = 6'd2, SX_LEVEL = 6'd3,
        SX_SPSID = 6'd4, SX_CHROMA = 6'd5, SX_SEP = 6'd6, SX_DEPTHL = 6'd7,
        SX_DEPTHC = 6'd8, SX_BYPASS = 6'd9, SX_SMPRES = 6'd10, SX_LISTPRES = 6'd11,
        SX_DELTA = 6'd12, SX_FNUM = 6'd13, SX_POCT = 6'd14, SX_POCLSB = 6'd15,
        SX_DPZ = 6'd16, SX_OFFNR = 6'd17, SX_OFFTB = 6'd18, SX_NCYC = 6'd19,
        SX_OFFREF = 6'd20, SX_MAXREF = 6'd21, SX_GAPS = 6'd22, SX_WIDTH = 6'd23,
        SX_HEIGHT = 6'd24, SX_FMO = 6'd25, SX_MBAFF = 6'd26, SX_D8 = 6'd27,
        SX_CROPF = 6'd28, SX_CROP0 = 6'd29, SX_CROP1 = 6'd30, SX_CROP2 = 6'd31,
        SX_CROP3 = 6'd32, SX_VUI = 6'd33, SX_DONE = 6'd34
    } t_step;

    typedef enum logic [1:0] {
        KIND_FIXED = 2'd0, KIND_UE = 2'd1, KIND_SE = 2'd2
    } t_kind;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_TRUNC = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic load_byte;
        logic step_bit;
        logic emit_trunc;
        logic clear_unit;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic finished;
    } t_dp_stat;

    typedef struct packed {
        logic [7:0]  profile;
        logic [7:0]  level;
        logic [4:0]  set_id;
        logic [1:0]  chroma_format;
        logic [2:0]  luma_depth_minus8;
        logic [3:0]  frame_num_bits_minus4;
        logic [1:0]  order_count_type;
        logic [4:0]  max_ref_frames;
        logic        frames_only;
        logic [15:0] width_samples;
        logic [15:0] height_samples;
        logic [1:0]  status;
    } t_result;

    function automatic t_kind step_kind(input t_step s);
        t_kind k;
        case (s)
            SX_SPSID, SX_CHROMA, SX_DEPTHL, SX_DEPTHC, SX_FNUM, SX_POCT,
            SX_POCLSB, SX_NCYC, SX_MAXREF, SX_WIDTH, SX_HEIGHT,
            SX_CROP0, SX_CROP1, SX_CROP2, SX_CROP3: k = KIND_UE;
            SX_DELTA, SX_OFFNR, SX_OFFTB, SX_OFFREF: k = KIND_SE;
            default: k = KIND_FIXED;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] step_width(input t_step s);
        logic [5:0] w;
        case (s)
            SX_HDR, SX_PROFILE, SX_CONSTR, SX_LEVEL: w = 6'd8;
            SX_SEP, SX_BYPASS, SX_SMPRES, SX_LISTPRES, SX_DPZ, SX_GAPS, SX_FMO,
            SX_MBAFF, SX_D8, SX_CROPF, SX_VUI, SX_DONE: w = 6'd1;
            default: w = 6'd0;
        endcase
        return w;
    endfunction

    function automatic logic high_profile(input logic [7:0] p);
        return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
               p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
               p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
               p == 8'd135;
    endfunction

endpackage

// ----- src/sps_datapath.sv -----
// bit-serial syntax datapath: field capture, exp-golomb decode, crop arithmetic
`timescale 1ns / 1ps
module sps_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sps_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]       i_byte,
    output sps_pkg::t_dp_stat o_stat,
    output sps_pkg::t_result o_result
);
    logic [7:0]      r_byte;
    sps_pkg::t_step  r_step, n_step;
    logic [5:0]      r_zero, n_zero;
    logic [32:0]     r_code, n_code;
    logic [5:0]      r_bl, n_bl;
    logic [3:0]      r_li, n_li;
    logic [6:0]      r_ei, n_ei;
    logic [7:0]      r_prev, n_prev;
    logic [7:0]      r_cyc, n_cyc;
    logic [11:0]     r_wmb, n_wmb;
    logic [11:0]     r_hun, n_hun;
    logic [15:0]     r_crop [4];
    logic [15:0]     n_crop [4];
    logic            r_sep, n_sep;
    logic            r_fin, n_fin;
    sps_pkg::t_result r_cap, n_cap;
    sps_pkg::t_result r_out, n_out;

    logic            hit;
    logic [1:0]      hit_stat;
    logic            dims_ok;
    logic [15:0]     dim_w, dim_h;

    // cropped dimensions from the registered state
    always_comb begin
        logic [1:0]  cat;
        logic [17:0] fw, fh, base;
        logic [16:0] sw, sh;
        logic [18:0] cw, ch;
        cat  = r_sep ? 2'd0 : r_cap.chroma_format;
        fw   = {1'b0, (13'(r_wmb) + 13'd1), 4'b0};
        base = {1'b0, (13'(r_hun) + 13'd1), 4'b0};
        fh   = r_cap.frames_only ? base : (base << 1);
        sw   = 17'(r_crop[0]) + 17'(r_crop[1]);
        sh   = 17'(r_crop[2]) + 17'(r_crop[3]);
        cw   = (cat == 2'd1 || cat == 2'd2) ? (19'(sw) << 1) : 19'(sw);
        ch   = 19'(sh) << ((cat == 2'd1 ? 1 : 0) + (r_cap.frames_only ? 0 : 1));
        dims_ok = (fh <= 18'(sps_pkg::DIM_LIMIT)) && (cw < 19'(fw)) && (ch < 19'(fh));
        dim_w   = 16'(19'(fw) - cw);
        dim_h   = 16'(19'(fh) - ch);
    end

    always_comb begin
        sps_pkg::t_kind kind;
        logic           b, go, neg, ent;
        logic [32:0]    sh, gv, v;
        logic [5:0]     bl;
        sps_pkg::t_step es;
        logic [7:0]     ns;
        logic [3:0]     li1;
        logic [6:0]     ei1;
        logic [7:0]     cy;
        n_step = r_step; n_zero = r_zero; n_code = r_code; n_bl = r_bl;
        n_li = r_li; n_ei = r_ei; n_prev = r_prev; n_cyc = r_cyc;
        n_wmb = r_wmb; n_hun = r_hun; n_crop = r_crop; n_sep = r_sep;
        n_fin = r_fin; n_cap = r_cap;
        hit = 1'b0; hit_stat = sps_pkg::STAT_OK;
        go = 1'b0; neg = 1'b0; ent = 1'b0; es = sps_pkg::SX_DONE;
        v = '0; gv = '0; ns = '0; li1 = '0; ei1 = '0; cy = '0;
        kind = sps_pkg::step_kind(r_step);
        b  = r_byte[7];
        sh = {r_code[31:0], b};
        bl = r_bl - 6'(r_bl != 6'd0);
        if (i_cmd.step_bit && !r_fin && r_step != sps_pkg::SX_DONE) begin
            if (kind == sps_pkg::KIND_FIXED) begin
                n_code = sh; n_bl = bl;
                if (bl == 6'd0) begin go = 1'b1; v = sh; end
            end else begin
                if (r_bl != 6'd0) begin
                    if (bl != 6'd0) begin n_code = sh; n_bl = bl; end
                    else begin go = 1'b1; gv = sh - 33'd1; end
                end else if (!b) begin
                    if (r_zero >= 6'(sps_pkg::GOLOMB_MAX_BITS)) begin
                        hit = 1'b1; hit_stat = sps_pkg::STAT_RANGE;
                    end else n_zero = r_zero + 6'd1;
                end else if (r_zero != 6'd0) begin
                    n_bl = r_zero; n_code = 33'd1;
                end else begin
                    go = 1'b1; gv = '0;
                end
                if (kind == sps_pkg::KIND_SE) begin
                    if (gv[0]) v = (gv + 33'd1) >> 1;
                    else begin v = gv >> 1; neg = 1'b1; end
                end else v = gv;
            end
        end
        li1 = r_li + 4'd1;
        if (go) begin
            ent = 1'b1;
            case (r_step)
                sps_pkg::SX_HDR:    es = sps_pkg::SX_PROFILE;
                sps_pkg::SX_PROFILE: begin n_cap.profile = v[7:0]; es = sps_pkg::SX_CONSTR; end
                sps_pkg::SX_CONSTR: es = sps_pkg::SX_LEVEL;
                sps_pkg::SX_LEVEL:  begin n_cap.level = v[7:0]; es = sps_pkg::SX_SPSID; end
                sps_pkg::SX_SPSID: begin
                    if (v > 33'd31) ent = 1'b0;
                    else begin
                        n_cap.set_id = v[4:0];
                        es = sps_pkg::high_profile(r_cap.profile) ? sps_pkg::SX_CHROMA
                                                                   : sps_pkg::SX_FNUM;
                    end
                end
                sps_pkg::SX_CHROMA: begin
                    if (v > 33'd3) ent = 1'b0;
                    else begin
                        n_cap.chroma_format = v[1:0];
                        es = (v == 33'd3) ? sps_pkg::SX_SEP : sps_pkg::SX_DEPTHL;
                    end
                end
                sps_pkg::SX_SEP: begin n_sep = v[0]; es = sps_pkg::SX_DEPTHL; end
                sps_pkg::SX_DEPTHL: begin
                    if (v > 33'd6) ent = 1'b0;
                    else begin n_cap.luma_depth_minus8 = v[2:0]; es = sps_pkg::SX_DEPTHC; end
                end
                sps_pkg::SX_DEPTHC: begin
                    if (v > 33'd6) ent = 1'b0; else es = sps_pkg::SX_BYPASS;
                end
                sps_pkg::SX_BYPASS: es = sps_pkg::SX_SMPRES;
                sps_pkg::SX_SMPRES: begin
                    n_li = '0;
                    es = v[0] ? sps_pkg::SX_LISTPRES : sps_pkg::SX_FNUM;
                end
                sps_pkg::SX_LISTPRES: begin
                    if (v[0]) begin
                        n_ei = '0; n_prev = 8'd8; es = sps_pkg::SX_DELTA;
                    end else begin
                        n_li = li1;
                        es = (li1 >= ((r_cap.chroma_format != 2'd3) ? 4'd8 : 4'd12))
                             ? sps_pkg::SX_FNUM : sps_pkg::SX_LISTPRES;
                    end
                end
                sps_pkg::SX_DELTA: begin
                    if (neg ? (v > 33'd128) : (v > 33'd127)) ent = 1'b0;
                    else begin
                        ns  = neg ? (r_prev - v[7:0]) : (r_prev + v[7:0]);
                        ei1 = r_ei + 7'd1;
                        if (ns != 8'd0) n_prev = ns;
                        n_ei = ei1;
                        if (ei1 >= ((r_li < 4'd6) ? 7'd16 : 7'd64) || ns == 8'd0) begin
                            n_li = li1;
                            es = (li1 >= ((r_cap.chroma_format != 2'd3) ? 4'd8 : 4'd12))
                                 ? sps_pkg::SX_FNUM : sps_pkg::SX_LISTPRES;
                        end else es = sps_pkg::SX_DELTA;
                    end
                end
                sps_pkg::SX_FNUM: begin
                    if (v > 33'd12) ent = 1'b0;
                    else begin n_cap.frame_num_bits_minus4 = v[3:0]; es = sps_pkg::SX_POCT; end
                end
                sps_pkg::SX_POCT: begin
                    if (v > 33'd2) ent = 1'b0;
                    else begin
                        n_cap.order_count_type = v[1:0];
                        es = (v == 33'd0) ? sps_pkg::SX_POCLSB :
                             (v == 33'd1) ? sps_pkg::SX_DPZ : sps_pkg::SX_MAXREF;
                    end
                end
                sps_pkg::SX_POCLSB: begin
                    if (v > 33'd12) ent = 1'b0; else es = sps_pkg::SX_MAXREF;
                end
                sps_pkg::SX_DPZ:   es = sps_pkg::SX_OFFNR;
                sps_pkg::SX_OFFNR: es = sps_pkg::SX_OFFTB;
                sps_pkg::SX_OFFTB: es = sps_pkg::SX_NCYC;
                sps_pkg::SX_NCYC: begin
                    if (v > 33'(sps_pkg::MAX_CYCLE_FRAMES)) ent = 1'b0;
                    else begin
                        n_cyc = v[7:0];
                        es = (v == 33'd0) ? sps_pkg::SX_MAXREF : sps_pkg::SX_OFFREF;
                    end
                end
                sps_pkg::SX_OFFREF: begin
                    cy = (r_cyc != 8'd0) ? (r_cyc - 8'd1) : r_cyc;
                    n_cyc = cy;
                    es = (cy == 8'd0) ? sps_pkg::SX_MAXREF : sps_pkg::SX_OFFREF;
                end
                sps_pkg::SX_MAXREF: begin
                    if (v > 33'd16) ent = 1'b0;
                    else begin n_cap.max_ref_frames = v[4:0]; es = sps_pkg::SX_GAPS; end
                end
                sps_pkg::SX_GAPS: es = sps_pkg::SX_WIDTH;
                sps_pkg::SX_WIDTH: begin
                    if (v > 33'(sps_pkg::DIM_MAX_MBS)) ent = 1'b0;
                    else begin n_wmb = v[11:0]; es = sps_pkg::SX_HEIGHT; end
                end
                sps_pkg::SX_HEIGHT: begin
                    if (v > 33'(sps_pkg::DIM_MAX_MBS)) ent = 1'b0;
                    else begin n_hun = v[11:0]; es = sps_pkg::SX_FMO; end
                end
                sps_pkg::SX_FMO: begin
                    n_cap.frames_only = v[0];
                    es = v[0] ? sps_pkg::SX_D8 : sps_pkg::SX_MBAFF;
                end
                sps_pkg::SX_MBAFF: es = sps_pkg::SX_D8;
                sps_pkg::SX_D8:    es = sps_pkg::SX_CROPF;
                sps_pkg::SX_CROPF: es = v[0] ? sps_pkg::SX_CROP0 : sps_pkg::SX_VUI;
                sps_pkg::SX_CROP0: begin
                    if (v > 33'hFFFF) ent = 1'b0;
                    else begin n_crop[0] = v[15:0]; es = sps_pkg::SX_CROP1; end
                end
                sps_pkg::SX_CROP1: begin
                    if (v > 33'hFFFF) ent = 1'b0;
                    else begin n_crop[1] = v[15:0]; es = sps_pkg::SX_CROP2; end
                end
                sps_pkg::SX_CROP2: begin
                    if (v > 33'hFFFF) ent = 1'b0;
                    else begin n_crop[2] = v[15:0]; es = sps_pkg::SX_CROP3; end
                end
                sps_pkg::SX_CROP3: begin
                    if (v > 33'hFFFF) ent = 1'b0;
                    else begin n_crop[3] = v[15:0]; es = sps_pkg::SX_VUI; end
                end
                sps_pkg::SX_VUI: begin
                    es = sps_pkg::SX_DONE; hit = 1'b1;
                    hit_stat = dims_ok ? sps_pkg::STAT_OK : sps_pkg::STAT_RANGE;
                end
                default: es = sps_pkg::SX_DONE;
            endcase
            // a failed range check stops the unit with an error word
            if (!ent) begin hit = 1'b1; hit_stat = sps_pkg::STAT_RANGE; end
        end
        if (ent) begin
            n_step = es; n_zero = '0; n_code = '0; n_bl = sps_pkg::step_width(es);
        end
        if (hit) n_fin = 1'b1;
    end

    // result word: captured fields, dimensions only on a clean parse
    always_comb begin
        n_out = r_cap;
        n_out.width_samples  = (hit && hit_stat == sps_pkg::STAT_OK) ? dim_w : '0;
        n_out.height_samples = (hit && hit_stat == sps_pkg::STAT_OK) ? dim_h : '0;
        n_out.status         = hit ? hit_stat : sps_pkg::STAT_TRUNC;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) r_byte <= i_byte;
        else if (i_cmd.step_bit) r_byte <= {r_byte[6:0], 1'b0};
        if (!i_rst_n || i_cmd.clear_unit) begin
            r_step <= sps_pkg::SX_HDR; r_zero <= '0; r_code <= '0;
            r_bl <= sps_pkg::step_width(sps_pkg::SX_HDR);
            r_li <= '0; r_ei <= '0; r_prev <= 8'd8; r_cyc <= '0;
            r_wmb <= '0; r_hun <= '0; r_sep <= 1'b0; r_fin <= 1'b0;
            for (int i = 0; i < 4; i++) r_crop[i] <= '0;
            r_cap <= '{chroma_format: 2'd1, default: '0};
        end else begin
            r_step <= n_step; r_zero <= n_zero; r_code <= n_code; r_bl <= n_bl;
            r_li <= n_li; r_ei <= n_ei; r_prev <= n_prev; r_cyc <= n_cyc;
            r_wmb <= n_wmb; r_hun <= n_hun; r_crop <= n_crop; r_sep <= n_sep;
            r_fin <= n_fin; r_cap <= n_cap;
        end
        if (hit || (i_cmd.emit_trunc && !r_fin)) r_out <= n_out;
    end

    assign o_stat.hit      = hit;
    assign o_stat.finished = r_fin;
    assign o_result        = r_out;

endmodule

// ----- src/sps_ctrl.sv -----
// byte sequencer and output handshake control
`timescale 1ns / 1ps
module sps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  logic              i_tlast,
    output logic              o_tvalid,
    input  logic              i_tready,
    output sps_pkg::t_dp_cmd  o_cmd,
    input  sps_pkg::t_dp_stat i_stat
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_tready = (r_state == S_IDLE) && (!r_out_valid || i_stat.finished);
    assign accept   = i_tvalid && o_tready;
    assign o_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_last = r_last;
        n_out_valid = r_out_valid && !i_tready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_byte = 1'b1;
                    n_last = i_tlast; n_cnt = '0; n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.step_bit = 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) n_state = S_FINAL;
                if (i_stat.hit) n_out_valid = 1'b1;
            end
            S_FINAL: begin
                if (r_last) begin
                    o_cmd.clear_unit = 1'b1;
                    if (!i_stat.finished) begin
                        o_cmd.emit_trunc = 1'b1; n_out_valid = 1'b1;
                    end
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_last <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_last <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    a_hit_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.hit |-> r_state == S_SHIFT) else $error("result outside bit phase");
    a_hit_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.hit |-> !r_out_valid) else $error("result while output full");
    a_accept_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_SHIFT && r_cnt == 3'd0) else $error("byte not shifted");
    a_final_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_cnt == 3'd7) |=> r_state == S_FINAL)
        else $error("bit count lost");

endmodule

// ----- src/h264_sps_header_parser.sv -----
// top level of the h.264 sequence parameter set header parser
`timescale 1ns / 1ps
// channel   direction  tdata                               tlast
// s_axis    in         [7:0] data_byte                     last_byte
// m_axis    out        profile..status, 72 bits (below)    -
//
// each byte is accepted, run through eight bit steps of the
// shared exp-golomb / fixed-field shifter, then closed in a final state
// at most one result per unit; bytes after it are still taken while the
// result word waits, until the last byte of the unit clears the parse state
// reset is synchronous, active low, and leaves the parser at the header byte
module h264_sps_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] profile, [15:8] level, [20:16] set_id, [22:21] chroma_format,
    // [25:23] luma_depth_minus8, [29:26] frame_num_bits_minus4,
    // [31:30] order_count_type, [36:32] max_ref_frames, [37] frames_only,
    // [53:38] width_samples, [69:54] height_samples, [71:70] status
    output logic [71:0] m_axis_tdata
);
    sps_pkg::t_dp_cmd  cmd;
    sps_pkg::t_dp_stat stat;
    sps_pkg::t_result  res;

    // byte sequencing and handshakes
    sps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tlast  (s_axis_tlast),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    // syntax walk, captured fields and result word register
    sps_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (s_axis_tdata),
        .o_stat   (stat),
        .o_result (res)
    );

    // pack the result word, first field lowest
    assign m_axis_tdata = {res.status, res.height_samples, res.width_samples,
                           res.frames_only, res.max_ref_frames, res.order_count_type,
                           res.frame_num_bits_minus4, res.luma_depth_minus8,
                           res.chroma_format, res.set_id, res.level, res.profile};

endmodule

// ----- test/tb_h264_sps_header_parser.sv -----
// self-checking testbench of the h.264 sequence parameter set header parser
`timescale 1ns / 1ps

// parse-tracking scoreboard: mirrors the bit-serial syntax walk per byte
class sps_scoreboard;
    bit [71:0] expected_q[$];
    int        mismatches;
    int        words_checked;
    int        ok_words;
    int        trunc_words;
    int        range_words;

    sps_pkg::t_step cur_step;
    int        zrun, bleft, lidx, eidx, prev_sc, next_sc, ccount;
    int        wmbs, hunits, sep, fin;
    int        crop[4];
    bit [63:0] code;
    int        f_prof, f_lvl, f_id, f_cf, f_dl, f_fn, f_pt, f_ref, f_fo;

    function new();
        clear();
    endfunction

    function void clear();
        lidx = 0; eidx = 0; prev_sc = 8; next_sc = 8; ccount = 0;
        wmbs = 0; hunits = 0; sep = 0; fin = 0;
        foreach (crop[i]) crop[i] = 0;
        f_prof = 0; f_lvl = 0; f_id = 0; f_cf = 1; f_dl = 0;
        f_fn = 0; f_pt = 0; f_ref = 0; f_fo = 0;
        go(sps_pkg::SX_HDR);
    endfunction

    // 0 fixed, 1 unsigned golomb, 2 signed golomb
    function int code_kind(sps_pkg::t_step s);
        case (s)
            sps_pkg::SX_DELTA, sps_pkg::SX_OFFNR, sps_pkg::SX_OFFTB,
            sps_pkg::SX_OFFREF: return 2;
            sps_pkg::SX_HDR, sps_pkg::SX_PROFILE, sps_pkg::SX_CONSTR,
            sps_pkg::SX_LEVEL, sps_pkg::SX_SEP, sps_pkg::SX_BYPASS,
            sps_pkg::SX_SMPRES, sps_pkg::SX_LISTPRES, sps_pkg::SX_DPZ,
            sps_pkg::SX_GAPS, sps_pkg::SX_FMO, sps_pkg::SX_MBAFF,
            sps_pkg::SX_D8, sps_pkg::SX_CROPF, sps_pkg::SX_VUI,
            sps_pkg::SX_DONE: return 0;
            default: return 1;
        endcase
    endfunction

    function void go(int s);
        cur_step = (s <= int'(sps_pkg::SX_DONE)) ? sps_pkg::t_step'(s) : sps_pkg::SX_DONE;
        zrun = 0;
        code = 0;
        if (code_kind(cur_step) != 0) bleft = 0;
        else if (cur_step <= sps_pkg::SX_LEVEL) bleft = 8;
        else bleft = 1;
    endfunction

    function bit is_high(int p);
        case (p)
            100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135: return 1;
            default: return 0;
        endcase
    endfunction

    function void next_scaling_list();
        lidx++;
        go(lidx >= ((f_cf != 3) ? 8 : 12) ? sps_pkg::SX_FNUM : sps_pkg::SX_LISTPRES);
    endfunction

    // -1 nothing yet, 0 done, 2 out of range
    function int apply(longint v, bit neg);
        sps_pkg::t_step s;
        int sz;
        s = cur_step;
        case (s)
            sps_pkg::SX_HDR: go(sps_pkg::SX_PROFILE);
            sps_pkg::SX_PROFILE: begin f_prof = int'(v); go(sps_pkg::SX_CONSTR); end
            sps_pkg::SX_CONSTR: go(sps_pkg::SX_LEVEL);
            sps_pkg::SX_LEVEL: begin f_lvl = int'(v); go(sps_pkg::SX_SPSID); end
            sps_pkg::SX_SPSID: begin
                if (v > 31) return 2;
                f_id = int'(v);
                go(is_high(f_prof) ? sps_pkg::SX_CHROMA : sps_pkg::SX_FNUM);
            end
            sps_pkg::SX_CHROMA: begin
                if (v > 3) return 2;
                f_cf = int'(v);
                go(v == 3 ? sps_pkg::SX_SEP : sps_pkg::SX_DEPTHL);
            end
            sps_pkg::SX_SEP: begin sep = int'(v & 1); go(sps_pkg::SX_DEPTHL); end
            sps_pkg::SX_DEPTHL: begin
                if (v > 6) return 2;
                f_dl = int'(v);
                go(sps_pkg::SX_DEPTHC);
            end
            sps_pkg::SX_DEPTHC: begin
                if (v > 6) return 2;
                go(sps_pkg::SX_BYPASS);
            end
            sps_pkg::SX_BYPASS: go(sps_pkg::SX_SMPRES);
            sps_pkg::SX_SMPRES: begin
                lidx = 0;
                go(v != 0 ? sps_pkg::SX_LISTPRES : sps_pkg::SX_FNUM);
            end
            sps_pkg::SX_LISTPRES: begin
                if (v != 0) begin
                    eidx = 0; prev_sc = 8; next_sc = 8;
                    go(sps_pkg::SX_DELTA);
                end else begin
                    next_scaling_list();
                end
            end
            sps_pkg::SX_DELTA: begin
                sz = (lidx < 6) ? 16 : 64;
                if (neg ? (v > 128) : (v > 127)) return 2;
                next_sc = neg ? ((prev_sc - int'(v)) & 255) : ((prev_sc + int'(v)) & 255);
                if (next_sc != 0) prev_sc = next_sc;
                eidx++;
                if (eidx >= sz || next_sc == 0) next_scaling_list();
                else go(sps_pkg::SX_DELTA);
            end
            sps_pkg::SX_FNUM: begin
                if (v > 12) return 2;
                f_fn = int'(v);
                go(sps_pkg::SX_POCT);
            end
            sps_pkg::SX_POCT: begin
                if (v > 2) return 2;
                f_pt = int'(v);
                go(v == 0 ? sps_pkg::SX_POCLSB : (v == 1 ? sps_pkg::SX_DPZ : sps_pkg::SX_MAXREF));
            end
            sps_pkg::SX_POCLSB: begin
                if (v > 12) return 2;
                go(sps_pkg::SX_MAXREF);
            end
            sps_pkg::SX_DPZ: go(sps_pkg::SX_OFFNR);
            sps_pkg::SX_OFFNR: go(sps_pkg::SX_OFFTB);
            sps_pkg::SX_OFFTB: go(sps_pkg::SX_NCYC);
            sps_pkg::SX_NCYC: begin
                if (v > sps_pkg::MAX_CYCLE_FRAMES) return 2;
                ccount = int'(v);
                go(v == 0 ? sps_pkg::SX_MAXREF : sps_pkg::SX_OFFREF);
            end
            sps_pkg::SX_OFFREF: begin
                if (ccount > 0) ccount--;
                go(ccount == 0 ? sps_pkg::SX_MAXREF : sps_pkg::SX_OFFREF);
            end
            sps_pkg::SX_MAXREF: begin
                if (v > 16) return 2;
                f_ref = int'(v);
                go(sps_pkg::SX_GAPS);
            end
            sps_pkg::SX_GAPS: go(sps_pkg::SX_WIDTH);
            sps_pkg::SX_WIDTH: begin
                if (v > sps_pkg::DIM_MAX_MBS) return 2;
                wmbs = int'(v);
                go(sps_pkg::SX_HEIGHT);
            end
            sps_pkg::SX_HEIGHT: begin
                if (v > sps_pkg::DIM_MAX_MBS) return 2;
                hunits = int'(v);
                go(sps_pkg::SX_FMO);
            end
            sps_pkg::SX_FMO: begin
                f_fo = int'(v & 1);
                go(v != 0 ? sps_pkg::SX_D8 : sps_pkg::SX_MBAFF);
            end
            sps_pkg::SX_MBAFF: go(sps_pkg::SX_D8);
            sps_pkg::SX_D8: go(sps_pkg::SX_CROPF);
            sps_pkg::SX_CROPF: go(v != 0 ? sps_pkg::SX_CROP0 : sps_pkg::SX_VUI);
            sps_pkg::SX_CROP0, sps_pkg::SX_CROP1, sps_pkg::SX_CROP2, sps_pkg::SX_CROP3: begin
                if (v > 65535) return 2;
                crop[int'(s) - int'(sps_pkg::SX_CROP0)] = int'(v);
                go(int'(s) + 1);
            end
            sps_pkg::SX_VUI: begin go(sps_pkg::SX_DONE); return 0; end
            default: go(sps_pkg::SX_DONE);
        endcase
        return -1;
    endfunction

    function int take_bit(bit b);
        int k;
        k = code_kind(cur_step);
        if (fin != 0 || cur_step == sps_pkg::SX_DONE) return -1;
        if (k == 0) begin
            code = (code << 1) | b;
            if (bleft > 0) bleft--;
            if (bleft == 0) return apply(code, 0);
            return -1;
        end
        if (bleft > 0) begin
            code = (code << 1) | b;
            bleft--;
            if (bleft > 0) return -1;
            code = code - 1;
        end else if (b == 0) begin
            if (zrun >= sps_pkg::GOLOMB_MAX_BITS) return 2;
            zrun++;
            return -1;
        end else if (zrun != 0) begin
            bleft = zrun;
            code = 1;
            return -1;
        end else begin
            code = 0;
        end
        if (k == 2) begin
            if (code[0]) return apply((code + 1) >> 1, 0);
            return apply(code >> 1, 1);
        end
        return apply(code, 0);
    endfunction

    function void push_result(int st);
        longint fw, fh, cw, ch, fm;
        int cat, sw, sh;
        bit [15:0] w, h;
        w = 0; h = 0;
        if (st == 0) begin
            cat = (sep != 0) ? 0 : (f_cf & 3);
            sw = (cat == 1 || cat == 2) ? 2 : 1;
            sh = (cat == 1) ? 2 : 1;
            fm = 2 - f_fo;
            fw = longint'(wmbs + 1) << 4;
            fh = fm * (longint'(hunits + 1) << 4);
            cw = sw * longint'(crop[0] + crop[1]);
            ch = sh * fm * longint'(crop[2] + crop[3]);
            if (fh > sps_pkg::DIM_LIMIT || cw >= fw || ch >= fh) st = 2;
            else begin w = 16'(fw - cw); h = 16'(fh - ch); end
        end
        if (st != 0) begin w = 0; h = 0; end
        case (st)
            0: ok_words++;
            1: trunc_words++;
            default: range_words++;
        endcase
        expected_q.insert(expected_q.size(),
                          {2'(st), h, w, 1'(f_fo), 5'(f_ref), 2'(f_pt), 4'(f_fn),
                           3'(f_dl), 2'(f_cf), 5'(f_id), 8'(f_lvl), 8'(f_prof)});
    endfunction

    // called for every byte the parser accepts
    function void note_byte(bit [7:0] d, bit last);
        int r;
        for (int i = 7; i >= 0; i--) begin
            if (fin != 0) break;
            r = take_bit(d[i]);
            if (r >= 0) begin
                push_result(r);
                fin = 1;
            end
        end
        if (last) begin
            if (fin == 0) push_result(sps_pkg::STAT_TRUNC);
            clear();
        end
    endfunction

    function void check_word(bit [71:0] got);
        int lo[12] = '{0, 8, 16, 21, 23, 26, 30, 32, 37, 38, 54, 70};
        int wd[12] = '{8, 8, 5, 2, 3, 4, 2, 5, 1, 16, 16, 2};
        string nm[12] = '{"profile", "level", "set_id", "chroma_format",
                          "luma_depth_minus8", "frame_num_bits_minus4",
                          "order_count_type", "max_ref_frames", "frames_only",
                          "width_samples", "height_samples", "status"};
        bit [71:0] exp_w;
        longint e, g, msk;
        words_checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
        end
        exp_w = expected_q.pop_front();
        for (int f = 0; f < 12; f++) begin
            msk = (longint'(1) << wd[f]) - 1;
            e = longint'(exp_w >> lo[f]) & msk;
            g = longint'(got >> lo[f]) & msk;
            if (e != g) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result %0d field %s expected %0d got %0d",
                             $realtime, words_checked, nm[f], e, g);
            end
        end
    endfunction
endclass

module tb_h264_sps_header_parser;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    sps_scoreboard sb;
    bit          sps_bits[$];
    bit [7:0]    unit_bytes[$];
    int          bytes_sent;
    int          units_sent;
    int          quiet;
    int          hold_cycles;
    int          golomb_count;
    int          bad_at;
    int          long_prefix;

    // directed knobs, -1 means random
    int          k_profile, k_chroma, k_poct, k_scale, k_big;

    h264_sps_header_parser dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic put_bits(longint v, int n);
        for (int i = n - 1; i >= 0; i--) sps_bits.insert(sps_bits.size(), v[i]);
    endtask

    // unsigned golomb code, with the planted range breach or overlong prefix
    task automatic put_ue(longint v);
        longint c;
        int len;
        golomb_count++;
        if (golomb_count == bad_at) begin
            if (long_prefix != 0) begin
                repeat (33 + $urandom_range(0, 6)) sps_bits.insert(sps_bits.size(), 1'b0);
                put_bits($urandom, 8);
                return;
            end
            v = 70000 + $urandom_range(0, 1000);
        end
        c = v + 1;
        len = 0;
        while ((c >> len) != 0) len++;
        repeat (len - 1) sps_bits.insert(sps_bits.size(), 1'b0);
        put_bits(c, len);
    endtask

    task automatic put_se(int v);
        if (v > 0) put_ue(2 * v - 1);
        else put_ue(-2 * v);
    endtask

    function automatic int pick_small(int hi_lim);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, hi_lim) :
                                             $urandom_range(0, (hi_lim < 3) ? hi_lim : 3);
    endfunction

    // builds one parameter set, header byte first, into unit_bytes
    task automatic compose_unit();
        int hi_list[13] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135};
        int prof, cf, pt, nlists, sz, prv, d, n, fo, wm, hm;
        bit [7:0] b;
        sps_bits.delete();
        unit_bytes.delete();
        golomb_count = 0;
        unit_bytes.insert(unit_bytes.size(), 8'($urandom));
        prof = (k_profile >= 0) ? k_profile :
               ($urandom_range(0, 9) < 6 ? hi_list[$urandom_range(0, 12)] : $urandom_range(0, 255));
        put_bits(prof, 8);
        put_bits($urandom, 8);
        put_bits($urandom, 8);
        put_ue(pick_small(31));
        cf = 1;
        if (prof inside {100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135}) begin
            cf = (k_chroma >= 0) ? k_chroma : $urandom_range(0, 3);
            put_ue(cf);
            if (cf == 3) put_bits($urandom, 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_bits($urandom, 1);
            if (k_scale >= 0 ? k_scale != 0 : $urandom_range(0, 2) == 0) begin
                put_bits(1, 1);
                nlists = (cf != 3) ? 8 : 12;
                for (int l = 0; l < nlists; l++) begin
                    if (k_scale == 1 || $urandom_range(0, 1) == 0) begin
                        put_bits(1, 1);
                        sz = (l < 6) ? 16 : 64;
                        prv = 8;
                        // a few full lists, most end early on a zero scale
                        n = (k_scale == 1 && l < 6) ? sz : $urandom_range(0, 5);
                        for (int j = 0; j < sz; j++) begin
                            if (j >= n) begin
                                d = (256 - prv) & 255;
                                if (d > 127) d -= 256;
                            end else begin
                                d = $urandom_range(0, 255) - 128;
                                if (((prv + d) & 255) == 0) d = (d == 127) ? 126 : d + 1;
                            end
                            put_se(d);
                            prv = (prv + d) & 255;
                            if (prv == 0) break;
                        end
                    end else begin
                        put_bits(0, 1);
                    end
                end
            end else begin
                put_bits(0, 1);
            end
        end
        put_ue($urandom_range(0, 12));
        pt = (k_poct >= 0) ? k_poct : $urandom_range(0, 2);
        put_ue(pt);
        if (pt == 0) put_ue($urandom_range(0, 12));
        else if (pt == 1) begin
            put_bits($urandom, 1);
            put_se($urandom_range(0, 2000) - 1000);
            put_se($urandom_range(0, 2000) - 1000);
            n = ($urandom_range(0, 19) == 0) ? 255 : pick_small(6);
            put_ue(n);
            repeat (n) put_se($urandom_range(0, 64) - 32);
        end
        put_ue(k_big > 0 ? 16 : $urandom_range(0, 16));
        put_bits($urandom, 1);
        fo = (k_big > 0) ? 1 : $urandom_range(0, 1);
        wm = (k_big > 0) ? sps_pkg::DIM_MAX_MBS :
             ($urandom_range(0, 9) == 0 ? $urandom_range(0, sps_pkg::DIM_MAX_MBS) :
                                          $urandom_range(0, 119));
        hm = (k_big > 0) ? sps_pkg::DIM_MAX_MBS :
             ($urandom_range(0, 9) == 0 ? $urandom_range(0, sps_pkg::DIM_MAX_MBS) :
                                          $urandom_range(0, 67));
        put_ue(wm);
        put_ue(hm);
        put_bits(fo, 1);
        if (fo == 0) put_bits($urandom, 1);
        put_bits($urandom, 1);
        if (k_big > 0 || $urandom_range(0, 1) == 0) begin
            put_bits(1, 1);
            for (int c = 0; c < 4; c++)
                put_ue(k_big > 1 ? 65535 :
                       ($urandom_range(0, 7) == 0 ? $urandom_range(0, 3000) : pick_small(8)));
        end else begin
            put_bits(0, 1);
        end
        put_bits($urandom, 1);
        put_bits($urandom, $urandom_range(0, 15));
        sps_bits.insert(sps_bits.size(), 1'b1);
        while (sps_bits.size() % 8 != 0) sps_bits.insert(sps_bits.size(), 1'b0);
        for (int i = 0; i < sps_bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++) b[7 - j] = sps_bits[i + j];
            unit_bytes.insert(unit_bytes.size(), b);
        end
    endtask

    // offers one byte and returns after the edge that takes it
    task automatic send_byte(bit [7:0] d, bit last);
        bit taken;
        if (quiet == 0 && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        sb.note_byte(d, last);
        bytes_sent++;
    endtask

    task automatic send_unit();
        foreach (unit_bytes[i]) send_byte(unit_bytes[i], i == unit_bytes.size() - 1);
        units_sent++;
    endtask

    task automatic random_unit();
        int mode;
        k_profile = -1; k_chroma = -1; k_poct = -1; k_scale = -1; k_big = 0;
        mode = $urandom_range(0, 19);
        bad_at = (mode < 3) ? $urandom_range(1, 14) : 0;
        long_prefix = (mode == 0);
        compose_unit();
        if (mode == 3 || mode == 4) begin
            // cut short before the vui flag, sometimes down to the header byte
            while (unit_bytes.size() > 1 + $urandom_range(0, 6)) void'(unit_bytes.pop_back());
        end else if (mode == 5) begin
            unit_bytes.delete();
            repeat ($urandom_range(1, 20)) unit_bytes.insert(unit_bytes.size(), 8'($urandom));
        end
        send_unit();
    endtask

    task automatic directed_unit(int prof, int cf, int pt, int scl, int big, int bad, int lp);
        k_profile = prof; k_chroma = cf; k_poct = pt; k_scale = scl; k_big = big;
        bad_at = bad; long_prefix = lp;
        compose_unit();
        send_unit();
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        bit       take;
        bit [71:0] word;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            take = m_axis_tvalid && m_axis_tready;
            word = m_axis_tdata;
            @(posedge i_clk);
            if (take) sb.check_word(word);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (quiet == 0 && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles = $urandom_range(0, 9);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int wait_cnt;
        sb = new();
        bytes_sent = 0; units_sent = 0; quiet = 0; hold_cycles = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: baseline, high profiles with 4:4:4 chroma and full lists,
        // each order count type, largest picture, crop overflow, range breach,
        // overlong golomb prefix, lone header byte, all-ones and all-zero bytes
        directed_unit(66, -1, 0, 0, 0, 0, 0);
        directed_unit(244, 3, 1, 1, 0, 0, 0);
        directed_unit(100, 0, 2, 1, 0, 0, 0);
        directed_unit(77, -1, 0, 0, 1, 0, 0);
        directed_unit(66, -1, 2, 0, 2, 0, 0);
        directed_unit(100, 2, 0, 0, 0, 1, 0);
        directed_unit(66, -1, 0, 0, 0, 2, 1);
        send_byte(8'h67, 1'b1);
        send_byte(8'h67, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        repeat (6) send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);

        // random well-formed units with planted faults, truncation and noise
        while (bytes_sent < 1200) begin
            if (units_sent == 30) hold_cycles = 400;
            if (bytes_sent > 1000) quiet = 1;
            random_unit();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        wait_cnt = 0;
        while (sb.expected_q.size() != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (40) @(posedge i_clk);

        $display("sent %0d units in %0d bytes, checked %0d result words",
                 units_sent, bytes_sent, sb.words_checked);
        $display("results: %0d parsed, %0d truncated, %0d out of range",
                 sb.ok_words, sb.trunc_words, sb.range_words);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (sb.expected_q.size() != 0)
                $display("%0d expected results never arrived", sb.expected_q.size());
            $display("%0d mismatches", sb.mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
